>>> hw/rtl/nfd_pkg.sv
// Shared types, constants and codes for the nonuniform finite difference unit.
package nfd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int SPC_W     = 31;
  localparam int SPAN_W    = 32;
  localparam int DIFF_W    = 33;
  localparam int DIV_W     = 66;
  localparam int QUO_W     = 33;
  localparam int CNT_W     = 6;

  // first derivative modes
  localparam logic [1:0] KIND_CENTRAL  = 2'd0;
  localparam logic [1:0] KIND_BACKWARD = 2'd1;
  localparam logic [1:0] KIND_FORWARD  = 2'd2;
  localparam logic [1:0] KIND_UPWIND   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_SHORT = 2'd3;

  // job shapes handed from front to back
  localparam logic [1:0] JOB_SHORT  = 2'd0;
  localparam logic [1:0] JOB_PAIR   = 2'd1;
  localparam logic [1:0] JOB_TRIPLE = 2'd2;

  // register byte address
  localparam logic [1:0] ADDR_KIND = 2'd0;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic [SPC_W-1:0]         spacing;
    logic signed [DATA_W-1:0] velocity;
    logic                     is_first;
    logic                     is_last;
  } point_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] first_derivative;
    logic signed [DATA_W-1:0] second_derivative;
    logic                     second_valid;
    logic                     run_end;
    logic [1:0]               status;
  } result_t;

  typedef struct packed {
    logic [1:0]               mode;
    logic                     last;
    logic [1:0]               kind;
    logic                     vnp;
    logic signed [DATA_W-1:0] older;
    logic signed [DATA_W-1:0] held;
    logic signed [DATA_W-1:0] smp;
    logic [SPC_W-1:0]         w;
    logic [SPC_W-1:0]         e;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> hw/rtl/nfd_divider.sv
// Shared iterative rounded divider: signed numerator over positive divisor, saturated to 32 bits.
module nfd_divider
  import nfd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DIV_W-1:0] num,
  input  logic [SPAN_W-1:0]       den,
  output logic                    done,
  output logic signed [DATA_W-1:0] quo,
  output logic                    sat
);

  localparam logic [2:0] D_IDLE = 3'd0;
  localparam logic [2:0] D_RND  = 3'd1;
  localparam logic [2:0] D_CHK  = 3'd2;
  localparam logic [2:0] D_ITER = 3'd3;
  localparam logic [2:0] D_FIN  = 3'd4;

  logic [2:0]        state;
  logic              neg;
  logic              ovf;
  logic [DIV_W-1:0]  mag;
  logic [SPAN_W-1:0] dsr;
  logic [SPAN_W-1:0] rem;
  logic [QUO_W-1:0]  qsh;
  logic [CNT_W-1:0]  cnt;
  logic [SPAN_W+1:0] trial;
  logic              q_big;

  assign trial = {1'b0, rem, qsh[QUO_W-1]} - {2'b00, dsr};
  assign q_big = neg ? (qsh > QUO_W'(33'h080000000)) : (qsh > QUO_W'(33'h07FFFFFFF));

  // step the long division one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      state <= D_IDLE;
    end else begin
      done <= (state == D_FIN);
      unique case (state)
        D_IDLE: begin
          if (start) begin
            neg   <= num[DIV_W-1];
            mag   <= num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
            dsr   <= den;
            state <= D_RND;
          end
        end
        D_RND: begin
          mag   <= mag + DIV_W'(dsr >> 1);
          state <= D_CHK;
        end
        D_CHK: begin
          if (mag >= {1'b0, dsr, {QUO_W{1'b0}}}) begin
            ovf   <= 1'b1;
            state <= D_FIN;
          end else begin
            ovf   <= 1'b0;
            rem   <= mag[QUO_W+SPAN_W-1:QUO_W];
            qsh   <= mag[QUO_W-1:0];
            cnt   <= CNT_W'(QUO_W - 1);
            state <= D_ITER;
          end
        end
        D_ITER: begin
          if (!trial[SPAN_W+1]) begin
            rem <= trial[SPAN_W-1:0];
          end else begin
            rem <= {rem[SPAN_W-2:0], qsh[QUO_W-1]};
          end
          qsh <= {qsh[QUO_W-2:0], ~trial[SPAN_W+1]};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          sat  <= ovf || q_big;
          if (ovf || q_big) begin
            quo <= neg ? DATA_W'(32'sh80000000) : DATA_W'(32'sh7FFFFFFF);
          end else begin
            quo <= neg ? -qsh[DATA_W-1:0] : qsh[DATA_W-1:0];
          end
          state <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/nfd_queue.sv
// Two-entry job queue between the front and back parts.
module nfd_queue
  import nfd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  job_t          push_job,
  input  logic          pop,
  output job_t          head,
  output queue_status_t qstat
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head        = slots[rd_ptr];
  assign qstat.full  = (count == 2'd2);
  assign qstat.empty = (count == 2'd0);

  // store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> hw/rtl/nfd_front.sv
// Front part: accepts grid points, keeps the three-point window and issues jobs.
module nfd_front
  import nfd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  point_t        in_data,
  input  logic [1:0]    kind,
  input  queue_status_t qstat,
  output logic          push,
  output job_t          push_job
);

  logic signed [DATA_W-1:0] older_sample;
  logic signed [DATA_W-1:0] held_sample;
  logic [SPC_W-1:0]         held_spacing;
  logic                     held_velocity_nonpositive;
  logic [1:0]               window_fill;
  logic                     take;
  logic                     restart;
  logic                     vnp;

  assign in_ready = !qstat.full;
  assign take     = in_valid && in_ready;
  assign restart  = in_data.is_first || (window_fill == 2'd0);
  assign vnp      = (in_data.velocity <= 0);

  // classify the point into a job
  always_comb begin
    push_job.last  = in_data.is_last;
    push_job.kind  = kind;
    push_job.vnp   = held_velocity_nonpositive;
    push_job.older = older_sample;
    push_job.held  = held_sample;
    push_job.smp   = in_data.sample;
    push_job.w     = held_spacing;
    push_job.e     = in_data.spacing;
    if (restart) begin
      push_job.mode = JOB_SHORT;
    end else if (window_fill == 2'd1) begin
      push_job.mode = JOB_PAIR;
    end else begin
      push_job.mode = JOB_TRIPLE;
    end
    push = take && (!restart || in_data.is_last);
  end

  // update the window
  always_ff @(posedge clk) begin
    if (rst) begin
      older_sample              <= '0;
      held_sample               <= '0;
      held_spacing              <= '0;
      held_velocity_nonpositive <= 1'b0;
      window_fill               <= 2'd0;
    end else if (take) begin
      if (in_data.is_last) begin
        window_fill <= 2'd0;
      end else begin
        older_sample              <= restart ? '0 : held_sample;
        held_sample               <= in_data.sample;
        held_spacing              <= restart ? '0 : in_data.spacing;
        held_velocity_nonpositive <= vnp;
        window_fill               <= restart ? 2'd1 : 2'd2;
      end
    end
  end

endmodule

>>> hw/rtl/nfd_back.sv
// Back part: runs slopes, weighted mean and second derivative on the shared divider.
module nfd_back
  import nfd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  job_t          head,
  input  queue_status_t qstat,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output result_t       out_data
);

  localparam logic [3:0] B_IDLE    = 4'd0;
  localparam logic [3:0] B_SE_GO   = 4'd1;
  localparam logic [3:0] B_SE_WAIT = 4'd2;
  localparam logic [3:0] B_SW_GO   = 4'd3;
  localparam logic [3:0] B_SW_WAIT = 4'd4;
  localparam logic [3:0] B_MUL1    = 4'd5;
  localparam logic [3:0] B_MUL2    = 4'd6;
  localparam logic [3:0] B_SUM     = 4'd7;
  localparam logic [3:0] B_D1_GO   = 4'd8;
  localparam logic [3:0] B_D1_WAIT = 4'd9;
  localparam logic [3:0] B_D2_GO   = 4'd10;
  localparam logic [3:0] B_D2_WAIT = 4'd11;
  localparam logic [3:0] B_EMIT1   = 4'd12;
  localparam logic [3:0] B_EMIT2   = 4'd13;

  logic [3:0]                 state;
  job_t                       job;
  logic [SPAN_W-1:0]          span;
  logic signed [DATA_W-1:0]   se;
  logic signed [DATA_W-1:0]   sw;
  logic signed [DATA_W-1:0]   d1;
  logic signed [DATA_W-1:0]   d2;
  logic                       sat_e;
  logic                       sat_w;
  logic                       sat_d2;
  logic signed [2*DATA_W-1:0] p1;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [DIV_W-1:0]    acc;
  logic signed [DATA_W-1:0]   mul_a;
  logic signed [DATA_W-1:0]   mul_b;
  logic                       div_start;
  logic signed [DIV_W-1:0]    div_num;
  logic [SPAN_W-1:0]          div_den;
  logic                       div_done;
  logic signed [DATA_W-1:0]   div_quo;
  logic                       div_sat;
  logic signed [DIFF_W-1:0]   diff_e;
  logic signed [DIFF_W-1:0]   diff_w;
  logic signed [DIFF_W-1:0]   diff_s;
  logic                       out_free;
  logic                       emit;
  logic                       zero_in;
  result_t                    end_res;
  result_t                    first_res;

  assign out_free = !out_valid || out_ready;
  assign emit     = ((state == B_EMIT1) || (state == B_EMIT2)) && out_free;
  assign pop      = (state == B_IDLE) && !qstat.empty;
  assign zero_in  = (job.w == '0) || (job.e == '0);

  assign diff_e = DIFF_W'(job.smp) - DIFF_W'(job.held);
  assign diff_w = DIFF_W'(job.held) - DIFF_W'(job.older);
  assign diff_s = DIFF_W'(se) - DIFF_W'(sw);

  // shared multiplier for the weighted mean
  assign mul_a = (state == B_MUL1) ? DATA_W'({1'b0, job.e}) : DATA_W'({1'b0, job.w});
  assign mul_b = (state == B_MUL1) ? sw : se;
  assign prod  = mul_a * mul_b;

  // pick the divider operands
  always_comb begin
    div_start = 1'b0;
    div_num   = DIV_W'(diff_e) <<< FRAC_BITS;
    div_den   = SPAN_W'(job.e);
    unique case (state)
      B_SE_GO: begin
        div_start = (job.mode != JOB_SHORT) && (job.e != '0);
      end
      B_SW_GO: begin
        div_start = 1'b1;
        div_num   = DIV_W'(diff_w) <<< FRAC_BITS;
        div_den   = SPAN_W'(job.w);
      end
      B_D1_GO: begin
        div_start = 1'b1;
        div_num   = acc;
        div_den   = span;
      end
      B_D2_GO: begin
        div_start = 1'b1;
        div_num   = DIV_W'(diff_s) <<< (FRAC_BITS + 1);
        div_den   = span;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  nfd_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .sat   (div_sat)
  );

  // build the end-point and first results
  always_comb begin
    end_res.first_derivative  = (job.e == '0) ? '0 : se;
    end_res.second_derivative = '0;
    end_res.second_valid      = 1'b0;
    end_res.run_end           = 1'b1;
    end_res.status            = (job.e == '0) ? ST_ZERO : (sat_e ? ST_SAT : ST_OK);
    first_res                 = end_res;
    first_res.run_end         = 1'b0;
    unique case (job.mode)
      JOB_SHORT: begin
        first_res.first_derivative = '0;
        first_res.run_end          = 1'b1;
        first_res.status           = ST_SHORT;
      end
      JOB_TRIPLE: begin
        if (zero_in) begin
          first_res.first_derivative = '0;
          first_res.status           = ST_ZERO;
        end else begin
          first_res.first_derivative  = d1;
          first_res.second_derivative = d2;
          first_res.second_valid      = 1'b1;
          first_res.status = (sat_e || sat_w || sat_d2) ? ST_SAT : ST_OK;
        end
      end
      default: begin
        first_res.run_end = 1'b0;
      end
    endcase
  end

  // sequence one job through the divider and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!qstat.empty) begin
            job   <= head;
            span  <= SPAN_W'(head.w) + SPAN_W'(head.e);
            state <= B_SE_GO;
          end
        end
        B_SE_GO: begin
          state <= div_start ? B_SE_WAIT : B_EMIT1;
        end
        B_SE_WAIT: begin
          if (div_done) begin
            se    <= div_quo;
            sat_e <= div_sat;
            state <= ((job.mode == JOB_PAIR) || (job.w == '0)) ? B_EMIT1 : B_SW_GO;
          end
        end
        B_SW_GO: begin
          state <= B_SW_WAIT;
        end
        B_SW_WAIT: begin
          if (div_done) begin
            sw    <= div_quo;
            sat_w <= div_sat;
            state <= B_MUL1;
          end
        end
        B_MUL1: begin
          p1 <= prod;
          unique case (job.kind)
            KIND_CENTRAL: begin
              state <= B_MUL2;
            end
            KIND_BACKWARD: begin
              d1    <= sw;
              state <= B_D2_GO;
            end
            KIND_FORWARD: begin
              d1    <= se;
              state <= B_D2_GO;
            end
            default: begin
              d1    <= job.vnp ? se : sw;
              state <= B_D2_GO;
            end
          endcase
        end
        B_MUL2: begin
          acc   <= DIV_W'(prod);
          state <= B_SUM;
        end
        B_SUM: begin
          acc   <= acc + DIV_W'(p1);
          state <= B_D1_GO;
        end
        B_D1_GO: begin
          state <= B_D1_WAIT;
        end
        B_D1_WAIT: begin
          if (div_done) begin
            d1    <= div_quo;
            state <= B_D2_GO;
          end
        end
        B_D2_GO: begin
          state <= B_D2_WAIT;
        end
        B_D2_WAIT: begin
          if (div_done) begin
            d2     <= div_quo;
            sat_d2 <= div_sat;
            state  <= B_EMIT1;
          end
        end
        B_EMIT1: begin
          if (out_free) begin
            out_data  <= first_res;
            state     <= (job.last && (job.mode != JOB_SHORT)) ? B_EMIT2 : B_IDLE;
          end
        end
        B_EMIT2: begin
          if (out_free) begin
            out_data  <= end_res;
            state     <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/nonuniform_finite_difference_unit.sv
// Top level of the nonuniform-grid three-point finite difference unit.
// Grid points stream in on the in channel; results for each point come out one point
// behind on the out channel, a point marked last giving two beats, or one when it opens
// its run. Every derivative goes through one shared divider that retires one quotient
// bit per cycle. An end point needs one division, an interior point needs three
// divisions and in central mode four plus the two multiplies and the add of the mean.
// A two-entry job queue lets the front take up to two further points while the back is
// busy. The mode register sits at byte address 0 of the APB port.
module nonuniform_finite_difference_unit
  import nfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  point_t      in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]    kind;
  logic          push;
  logic          pop;
  job_t          push_job;
  job_t          head;
  queue_status_t qstat;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_KIND) ? {30'd0, kind} : 32'd0;

  // hold the mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= KIND_CENTRAL;
    end else if (psel && penable && pwrite && (paddr == ADDR_KIND)) begin
      kind <= pwdata[1:0];
    end
  end

  nfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .kind     (kind),
    .qstat    (qstat),
    .push     (push),
    .push_job (push_job)
  );

  nfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  nfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/nfd_checker.sv
// Port-level checks for the finite difference unit, bound to the top level.
module nfd_checker
  import nfd_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // drop output valid right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

  // short runs close the run and carry no second derivative
  a_short: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_SHORT) |->
      out_data.run_end && !out_data.second_valid && (out_data.first_derivative == 0))
    else $error("bad short-run result");

  // second derivative only at interior points with usable status
  a_second: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.second_valid |->
      !out_data.run_end && ((out_data.status == ST_OK) || (out_data.status == ST_SAT)))
    else $error("second derivative on an end point");

  // zero-spacing results carry zero derivatives
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_ZERO) |->
      (out_data.first_derivative == 0) && (out_data.second_derivative == 0))
    else $error("nonzero derivative with zero spacing");

endmodule

bind nonuniform_finite_difference_unit nfd_checker u_nfd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> verif/nonuniform_finite_difference_unit_test.sv
// Self-checking testbench for the nonuniform-grid finite difference unit.
`timescale 1ns / 1ps

module nonuniform_finite_difference_unit_test;
  import nfd_pkg::*;

  localparam int RANDOM_PER_PHASE = 100;
  localparam int SETTLE_CYCLES    = 400;
  localparam int HOLD_CYCLES      = 600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  point_t      in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  result_t     out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = ADDR_KIND;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  nonuniform_finite_difference_unit dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Predictor state: mode register and the three-point window
  logic [1:0]               kind_now = KIND_CENTRAL;
  logic signed [DATA_W-1:0] win_older, win_held;
  logic [SPC_W-1:0]         win_spacing;
  bit                       win_vnp;
  int                       win_fill;

  point_t  pending_points[$];
  result_t expected_results[$];

  int  errors = 0;
  int  points_sent = 0;
  int  results_seen = 0;
  int  status_seen[4];
  bit  steady = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Rounded division, ties away from zero
  function automatic logic signed [95:0] round_quot(logic signed [95:0] num,
                                                   logic [95:0] den);
    logic [95:0] mag;
    logic [95:0] q;
    mag = (num < 0) ? -num : num;
    q = (mag + (den >> 1)) / den;
    return (num < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] clip32(logic signed [95:0] v, inout bit flag);
    if (v > 96'sh7FFFFFFF) begin
      flag = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -96'sh80000000) begin
      flag = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] grad(logic signed [31:0] a, logic signed [31:0] b,
                                              logic [SPC_W-1:0] h, inout bit flag);
    logic signed [95:0] d;
    d = b;
    d = (d - a) * (1 <<< FRAC_BITS);
    return clip32(round_quot(d, {65'b0, h}), flag);
  endfunction

  task automatic push_result(logic signed [31:0] d1, logic signed [31:0] d2, bit valid2,
                             bit last, logic [1:0] st);
    result_t r;
    r.first_derivative  = d1;
    r.second_derivative = d2;
    r.second_valid      = valid2;
    r.run_end           = last;
    r.status            = st;
    expected_results.push_back(r);
  endtask

  task automatic push_end(logic signed [31:0] a, logic signed [31:0] b,
                          logic [SPC_W-1:0] h, bit last);
    bit flag;
    logic signed [31:0] s;
    flag = 1'b0;
    if (h == 0) begin
      push_result(0, 0, 1'b0, last, ST_ZERO);
    end else begin
      s = grad(a, b, h, flag);
      push_result(s, 0, 1'b0, last, flag ? ST_SAT : ST_OK);
    end
  endtask

  // Advance the window by one accepted point and queue its results
  task automatic predict_point(point_t p);
    bit vnp, flag;
    logic signed [31:0] sw, se, d1, d2;
    logic signed [95:0] ws, es, span;
    vnp = (p.velocity <= 0);
    flag = 1'b0;
    if (p.is_first || win_fill == 0) begin
      if (p.is_last) begin
        push_result(0, 0, 1'b0, 1'b1, ST_SHORT);
        win_fill = 0;
      end else begin
        win_older = 0;
        win_held = p.sample;
        win_spacing = 0;
        win_vnp = vnp;
        win_fill = 1;
      end
      return;
    end
    if (win_fill == 1) begin
      push_end(win_held, p.sample, p.spacing, 1'b0);
    end else if (win_spacing == 0 || p.spacing == 0) begin
      push_result(0, 0, 1'b0, 1'b0, ST_ZERO);
    end else begin
      sw = grad(win_older, win_held, win_spacing, flag);
      se = grad(win_held, p.sample, p.spacing, flag);
      ws = $signed({65'b0, win_spacing});
      es = $signed({65'b0, p.spacing});
      span = ws + es;
      case (kind_now)
        KIND_CENTRAL:  d1 = 32'(round_quot(es * sw + ws * se, span));
        KIND_BACKWARD: d1 = sw;
        KIND_FORWARD:  d1 = se;
        default:       d1 = win_vnp ? se : sw;
      endcase
      d2 = clip32(round_quot((96'(se) - sw) * (2 <<< FRAC_BITS), span), flag);
      push_result(d1, d2, 1'b1, 1'b0, flag ? ST_SAT : ST_OK);
    end
    if (p.is_last) begin
      push_end(win_held, p.sample, p.spacing, 1'b1);
      win_fill = 0;
      return;
    end
    win_older = win_held;
    win_held = p.sample;
    win_spacing = p.spacing;
    win_vnp = vnp;
    win_fill = 2;
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch on result %0d: %s got %0h, expected %0h", results_seen, field, got,
             want);
  endtask

  // Driver: offer pending points, idle at random, predict on each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_point(in_data);
        points_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_points.size() > 0 && (steady || $urandom_range(99) >= 21)) begin
          in_data <= pending_points.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat, stall at random or hold off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", out_data.first_derivative, 32'd0);
        end else begin
          result_t want;
          want = expected_results.pop_front();
          if (out_data.first_derivative !== want.first_derivative)
            report_mismatch("first_derivative", out_data.first_derivative,
                            want.first_derivative);
          if (out_data.second_derivative !== want.second_derivative)
            report_mismatch("second_derivative", out_data.second_derivative,
                            want.second_derivative);
          if (out_data.second_valid !== want.second_valid)
            report_mismatch("second_valid", 32'(out_data.second_valid),
                            32'(want.second_valid));
          if (out_data.run_end !== want.run_end)
            report_mismatch("run_end", 32'(out_data.run_end), 32'(want.run_end));
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          status_seen[want.status]++;
        end
        results_seen++;
      end
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || $urandom_range(99) >= 21;
      end
    end
  end

  function automatic point_t make_point(logic signed [31:0] smp, logic [SPC_W-1:0] spc,
                                        logic signed [31:0] vel, bit first, bit last);
    point_t p;
    p.sample = smp;
    p.spacing = spc;
    p.velocity = vel;
    p.is_first = first;
    p.is_last = last;
    return p;
  endfunction

  function automatic logic [SPC_W-1:0] pick_spacing();
    case ($urandom_range(9))
      0:       return '0;
      1:       return SPC_W'(1);
      2:       return {SPC_W{1'b1}};
      3:       return SPC_W'($urandom);
      default: return SPC_W'($urandom_range(1 << 20, 1 << 10));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_sample(logic signed [31:0] prev);
    case ($urandom_range(4))
      0:       return $urandom;
      1:       return $urandom_range(3) == 0 ? 32'sh7FFFFFFF : 32'sh80000000;
      2:       return $signed($urandom_range(1 << 22)) - (1 << 21);
      default: return prev + $signed($urandom_range(1 << 18)) - (1 << 17);
    endcase
  endfunction

  // Queue one grid run of random content; noisy runs carry random markers
  task automatic add_run(int len, bit noisy);
    logic signed [31:0] smp;
    bit first, last;
    smp = $urandom;
    for (int i = 0; i < len; i++) begin
      smp = pick_sample(smp);
      first = noisy ? 1'($urandom_range(1)) : (i == 0);
      last = noisy ? ($urandom_range(3) == 0) : (i == len - 1);
      pending_points.push_back(make_point(smp, pick_spacing(), $urandom, first, last));
    end
  endtask

  task automatic wait_drained();
    while (pending_points.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic write_kind(logic [1:0] kind);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_KIND;
    pwdata <= 32'(kind);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    kind_now = kind;
  endtask

  task automatic add_directed();
    // single-point run, two-point run
    pending_points.push_back(make_point(32'sd5, 31'd7, 32'sd1, 1'b1, 1'b1));
    pending_points.push_back(make_point(32'sd0, 31'd0, 32'sd0, 1'b1, 1'b0));
    pending_points.push_back(make_point(32'sh10000, 31'h10000, -32'sd1, 1'b0, 1'b1));
    // saturating slopes over unit spacing, then a maximal spacing
    pending_points.push_back(make_point(32'sh80000000, 31'd9, 32'sh7FFFFFFF, 1'b1, 1'b0));
    pending_points.push_back(make_point(32'sh7FFFFFFF, 31'd1, 32'sh80000000, 1'b0, 1'b0));
    pending_points.push_back(make_point(32'sh80000000, 31'd1, 32'sd0, 1'b0, 1'b0));
    pending_points.push_back(make_point(32'sh7FFFFFFF, {SPC_W{1'b1}}, 32'sd3, 1'b0, 1'b1));
    // zero spacing at an interior point and at the end
    pending_points.push_back(make_point(32'sd100, 31'd3, 32'sd1, 1'b1, 1'b0));
    pending_points.push_back(make_point(32'sd200, 31'h8000, 32'sd1, 1'b0, 1'b0));
    pending_points.push_back(make_point(32'sd300, 31'd0, 32'sd1, 1'b0, 1'b0));
    pending_points.push_back(make_point(32'sd400, 31'd0, 32'sd1, 1'b0, 1'b1));
    // point without run start, then a restart while the run is open
    pending_points.push_back(make_point(-32'sd50, 31'd77, -32'sd1, 1'b0, 1'b0));
    pending_points.push_back(make_point(32'sd60, 31'h20000, -32'sd1, 1'b0, 1'b0));
    pending_points.push_back(make_point(-32'sd70, 31'h1000, 32'sd1, 1'b1, 1'b0));
    pending_points.push_back(make_point(32'sh40000, 31'h3000, 32'sd0, 1'b0, 1'b0));
    pending_points.push_back(make_point(32'sh90000, 31'h5000, 32'sd1, 1'b0, 1'b0));
    pending_points.push_back(make_point(32'sh10000, 31'h7000, -32'sd9, 1'b0, 1'b1));
  endtask

  initial begin
    logic [1:0] kind_plan[6] = '{KIND_CENTRAL, KIND_UPWIND, KIND_BACKWARD, KIND_FORWARD,
                                 KIND_UPWIND, KIND_CENTRAL};
    int added;
    int len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      // pause the sender until everything is back, then change mode
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      write_kind(kind_plan[ph]);
      steady = (ph == 4);
      if (ph == 0)
        add_directed();
      added = 0;
      while (added < RANDOM_PER_PHASE) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(12, 1) : $urandom_range(5, 1);
        add_run(len, $urandom_range(9) == 0);
        added += len;
      end
      // close any open run so the window is empty at the mode change
      pending_points.push_back(make_point($urandom, SPC_W'($urandom), $urandom, 1'b1, 1'b1));
      if (ph == 2) begin
        @(negedge clk);
        hold_req = 1'b1;
      end
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d grid points and %0d result beats over all four modes",
             points_sent, results_seen);
    $display("statuses: %0d ok, %0d saturated, %0d zero spacing, %0d too short",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[nonuniform_finite_difference_unit] OK");
    end else begin
      $display("[nonuniform_finite_difference_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("[nonuniform_finite_difference_unit] ERROR");
    $finish;
  end

endmodule
